// File: rtl/core/smx_pkg.sv
package smx_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int GAIN_W      = 20;
    localparam int GAIN_FRAC_W = 16;
    localparam int ACC_W       = 41;
    localparam int PROD_W      = SAMPLE_W + GAIN_W;
    localparam int SCALED_W    = PROD_W - GAIN_FRAC_W;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = GAIN_W;
    localparam int FMT_W       = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_FORMAT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_GAIN   = 1'd1;

    typedef enum logic [FMT_W-1:0] {
        FMT_S8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S32 = 2'd2
    } smx_fmt_t;

    localparam logic [FMT_W-1:0]  FMT_RESET  = FMT_S16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd65536;

    typedef struct packed {
        logic [FMT_W-1:0]  sample_format;
        logic [GAIN_W-1:0] volume_gain;
    } smx_cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mag;
        logic                neg;
        logic                last;
        logic                eob;
    } smx_entry_t;

    function automatic logic signed [SAMPLE_W-1:0] clamp_to_format(
        input logic signed [ACC_W-1:0] v,
        input logic [FMT_W-1:0]        fmt
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [ACC_W-1:0] r;
        case (fmt)
            FMT_S8:
            begin
                hi = ACC_W'(signed'(8'sh7f));
                lo = ACC_W'(signed'(8'sh80));
            end
            FMT_S16:
            begin
                hi = ACC_W'(signed'(16'sh7fff));
                lo = ACC_W'(signed'(16'sh8000));
            end
            default:
            begin
                hi = ACC_W'(signed'(32'sh7fffffff));
                lo = ACC_W'(signed'(32'sh80000000));
            end
        endcase
        if (v > hi)
        begin
            r = hi;
        end
        else if (v < lo)
        begin
            r = lo;
        end
        else
        begin
            r = v;
        end
        return r[SAMPLE_W-1:0];
    endfunction

endpackage

// File: rtl/core/smx_front.sv
module smx_front (
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [31:0]         source_sample,
    input  logic                       last_source,
    input  logic                       end_of_block,
    input  logic [1:0]                 sample_format,
    input  logic                       queue_full,
    output logic                       push,
    output smx_pkg::smx_entry_t        push_entry
);
    import smx_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_ext;

    always_comb
    begin
        case (sample_format)
            FMT_S8:  sample_ext = SAMPLE_W'(signed'(source_sample[7:0]));
            FMT_S16: sample_ext = SAMPLE_W'(signed'(source_sample[15:0]));
            default: sample_ext = source_sample;
        endcase
    end

    always_comb
    begin
        push_entry.neg  = sample_ext[SAMPLE_W-1];
        push_entry.mag  = sample_ext[SAMPLE_W-1] ? (~sample_ext + SAMPLE_W'(1)) : sample_ext;
        push_entry.last = last_source;
        push_entry.eob  = end_of_block;
    end

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

endmodule

// File: rtl/core/smx_queue.sv
module smx_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  smx_pkg::smx_entry_t push_entry,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output smx_pkg::smx_entry_t head_entry
);
    import smx_pkg::*;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    smx_entry_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full       = (count_reg == COUNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + COUNT_W'(1);
            2'b01:   count_next = count_reg - COUNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("Queue holds more entries than its depth.");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("Transfer into a full queue.");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("Read from an empty queue.");

endmodule

// File: rtl/core/smx_back.sv
module smx_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  smx_pkg::smx_cfg_t          cfg,
    input  logic                       queue_empty,
    input  smx_pkg::smx_entry_t        head_entry,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [31:0]         mixed_sample,
    output logic                       last_of_block
);
    import smx_pkg::*;

    logic                       advance;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [PROD_W-1:0]          s1_prod_reg;
    logic                       s1_neg_reg;
    logic                       s1_last_reg;
    logic                       s1_eob_reg;

    logic                       s2_valid_reg;
    logic                       s2_valid_next;
    logic signed [SAMPLE_W-1:0] s2_term_reg;
    logic                       s2_last_reg;
    logic                       s2_eob_reg;

    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_eob_reg;

    logic [PROD_W-1:0]          product;
    logic [SCALED_W-1:0]        scaled_mag;
    logic signed [SCALED_W:0]   scaled;
    logic signed [SAMPLE_W-1:0] term;
    logic signed [ACC_W:0]      acc_sum;
    logic signed [ACC_W-1:0]    acc_sat;
    logic                       emit;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !queue_empty;
    assign emit    = advance && s2_valid_reg && s2_last_reg;

    assign product = PROD_W'(head_entry.mag) * PROD_W'(cfg.volume_gain);

    always_comb
    begin
        scaled_mag = s1_prod_reg[PROD_W-1:GAIN_FRAC_W];
        scaled     = s1_neg_reg ? -signed'({1'b0, scaled_mag}) : signed'({1'b0, scaled_mag});
        term       = clamp_to_format(ACC_W'(scaled), cfg.sample_format);
    end

    always_comb
    begin
        acc_sum = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(s2_term_reg);
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            s1_valid_next = pop;
            s2_valid_next = s1_valid_reg;
            if (s2_valid_reg)
            begin
                acc_next = s2_last_reg ? '0 : acc_sat;
            end
            if (emit)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_prod_reg <= product;
            s1_neg_reg  <= head_entry.neg;
            s1_last_reg <= head_entry.last;
            s1_eob_reg  <= head_entry.eob;
            s2_term_reg <= term;
            s2_last_reg <= s1_last_reg;
            s2_eob_reg  <= s1_eob_reg;
        end
        if (emit)
        begin
            out_sample_reg <= clamp_to_format(acc_sat, cfg.sample_format);
            out_eob_reg    <= s2_eob_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mixed_sample  = out_sample_reg;
    assign last_of_block = out_eob_reg;

    a_acc_cleared_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (acc_reg == '0))
        else $error("Accumulator not cleared after a result was produced.");

    a_pipe_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> (!pop && !emit))
        else $error("Back pipeline moved while the result was stalled.");

    a_output_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((cfg.sample_format != FMT_S8)
                || (out_sample_reg <= 32'sd127 && out_sample_reg >= -32'sd128))
            && ((cfg.sample_format != FMT_S16)
                || (out_sample_reg <= 32'sd32767 && out_sample_reg >= -32'sd32768)))
        else $error("Mixed sample outside the format range.");

endmodule

// File: rtl/core/saturating_audio_mixer_top.sv
// Saturating audio mixer. Each input transfer brings one source sample of one sample position;
// it is scaled by the Q4.16 volume gain, truncated toward zero, clamped to the configured
// format and accumulated, and the transfer marked last_source produces one clamped mixed
// sample. The block takes one input transfer every cycle while its queue is not full, set by
// the single 32 by 20 bit multiplier and the accumulator stage that each handle one sample
// per cycle. A result passes from its last source transfer through the input queue, then the
// multiply and scale stages, and the accumulate stage loads the output register.
// While the output is stalled the queue absorbs up to QUEUE_DEPTH further transfers before
// the input stalls.
module saturating_audio_mixer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [smx_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [smx_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [31:0]                  source_sample,
    input  logic                                last_source,
    input  logic                                end_of_block,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [31:0]                  mixed_sample,
    output logic                                last_of_block
);
    import smx_pkg::*;

    logic [FMT_W-1:0]  sample_format_reg;
    logic [GAIN_W-1:0] volume_gain_reg;
    smx_cfg_t          cfg;
    logic              queue_full;
    logic              queue_empty;
    logic              push;
    logic              pop;
    smx_entry_t        push_entry;
    smx_entry_t        head_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_format_reg <= FMT_RESET;
            volume_gain_reg   <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SAMPLE_FORMAT: sample_format_reg <= cfg_data[FMT_W-1:0];
                CFG_VOLUME_GAIN:   volume_gain_reg   <= cfg_data[GAIN_W-1:0];
                default:           volume_gain_reg   <= volume_gain_reg;
            endcase
        end
    end

    assign cfg.sample_format = sample_format_reg;
    assign cfg.volume_gain   = volume_gain_reg;

    smx_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .source_sample (source_sample),
        .last_source   (last_source),
        .end_of_block  (end_of_block),
        .sample_format (sample_format_reg),
        .queue_full    (queue_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    smx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .empty      (queue_empty),
        .head_entry (head_entry)
    );

    smx_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .queue_empty   (queue_empty),
        .head_entry    (head_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mixed_sample  (mixed_sample),
        .last_of_block (last_of_block)
    );

endmodule

// File: verif/saturating_audio_mixer_top_tb.sv
module saturating_audio_mixer_top_tb;

    import smx_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_PERCENT = 13;
    localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 20'hfffff;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 20'd65536;
    localparam longint ACC_HI = 64'sd1099511627775;
    localparam longint ACC_LO = -64'sd1099511627776;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       eob;
    } mix_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [31:0]         source_sample;
    logic                       last_source;
    logic                       end_of_block;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [31:0]         mixed_sample;
    logic                       last_of_block;

    logic [FMT_W-1:0]           fmt_q;
    logic [GAIN_W-1:0]          gain_q;
    longint                     mix_acc;
    mix_result_t                pending_mixes[$];
    int                         mismatch_count;
    int                         cycle_count;
    bit                         idle_on;

    saturating_audio_mixer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .source_sample (source_sample),
        .last_source   (last_source),
        .end_of_block  (end_of_block),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mixed_sample  (mixed_sample),
        .last_of_block (last_of_block)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("saturating_audio_mixer_top_tb: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
    end

    function automatic longint format_clamp(input longint v, input logic [FMT_W-1:0] fmt);
        longint hi;
        case (fmt)
            FMT_S8:  hi = 64'sd127;
            FMT_S16: hi = 64'sd32767;
            default: hi = 64'sd2147483647;
        endcase
        if (v > hi)
        begin
            return hi;
        end
        if (v < -hi - 1)
        begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic longint scale_source(input logic [31:0] raw);
        longint s;
        longint unsigned mag;
        longint unsigned p;
        case (fmt_q)
            FMT_S8:  s = longint'(signed'(raw[7:0]));
            FMT_S16: s = longint'(signed'(raw[15:0]));
            default: s = longint'(signed'(raw));
        endcase
        mag = (s < 0) ? longint'(-s) : longint'(s);
        p = (mag * longint'(gain_q)) >> GAIN_FRAC_W;
        return format_clamp((s < 0) ? -longint'(p) : longint'(p), fmt_q);
    endfunction

    // Accumulates one accepted source transfer and queues the mix it closes.
    function automatic void mix_source(input logic [31:0] raw, input logic last,
                                       input logic eob);
        mix_result_t r;
        mix_acc = mix_acc + scale_source(raw);
        if (mix_acc > ACC_HI)
        begin
            mix_acc = ACC_HI;
        end
        if (mix_acc < ACC_LO)
        begin
            mix_acc = ACC_LO;
        end
        if (last)
        begin
            r.sample = 32'(format_clamp(mix_acc, fmt_q));
            r.eob = eob;
            pending_mixes.insert(pending_mixes.size(), r);
            mix_acc = 0;
        end
    endfunction

    always @(posedge clk)
    begin
        mix_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_mixes.size() == 0)
            begin
                $display("%0t: unexpected mix: expected none, actual sample %0d eob %0b",
                         $time, mixed_sample, last_of_block);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                exp_r = pending_mixes[0];
                pending_mixes.delete(0);
                if (mixed_sample !== exp_r.sample)
                begin
                    $display("%0t: mixed_sample: expected %0d, actual %0d",
                             $time, exp_r.sample, mixed_sample);
                    mismatch_count = mismatch_count + 1;
                end
                if (last_of_block !== exp_r.eob)
                begin
                    $display("%0t: last_of_block: expected %0b, actual %0b",
                             $time, exp_r.eob, last_of_block);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    task automatic send_source(input logic [31:0] raw, input logic last, input logic eob);
        while (idle_on && ($urandom_range(99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        source_sample <= raw;
        last_source <= last;
        end_of_block <= eob;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        mix_source(raw, last, eob);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_mixes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_SAMPLE_FORMAT)
        begin
            fmt_q = data[FMT_W-1:0];
        end
        else
        begin
            gain_q = data;
        end
    endtask

    // The unused upper bits of a format write are filled with noise at random.
    task automatic set_mix_config(input logic [FMT_W-1:0] fmt, input logic [GAIN_W-1:0] gain);
        logic [CFG_DATA_W-1:0] fmt_word;
        fmt_word = CFG_DATA_W'(fmt);
        if ($urandom_range(1))
        begin
            fmt_word = (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(3)) | CFG_DATA_W'(fmt);
        end
        write_register(CFG_SAMPLE_FORMAT, fmt_word);
        write_register(CFG_VOLUME_GAIN, gain);
    endtask

    function automatic logic [31:0] pick_sample();
        logic [31:0] raw;
        int w;
        raw = $urandom;
        w = (fmt_q == FMT_S8) ? 8 : (fmt_q == FMT_S16) ? 16 : 32;
        case ($urandom_range(9))
            0: raw = 32'((64'sd1 <<< (w - 1)) - 1);
            1: raw = 32'(-(64'sd1 <<< (w - 1)));
            2: raw = 32'(int'($urandom_range(2)) - 1);
            3: raw = $urandom;
            default:
            begin
                if (w < 32)
                begin
                    raw = raw << (32 - w);
                    raw = 32'(signed'(raw) >>> (32 - w));
                end
            end
        endcase
        return raw;
    endfunction

    task automatic test_reset_defaults();
        send_source(32'sd32767, 1'b1, 1'b0);
        send_source(-32'sd32768, 1'b1, 1'b1);
        send_source(32'sd1, 1'b0, 1'b0);
        send_source(-32'sd1, 1'b1, 1'b0);
    endtask

    task automatic test_format_extremes();
        set_mix_config(FMT_S8, GAIN_UNITY);
        send_source(32'sd127, 1'b1, 1'b0);
        send_source(-32'sd128, 1'b1, 1'b1);
        send_source(32'h1234_5680, 1'b1, 1'b0);
        send_source(32'sd100, 1'b0, 1'b0);
        send_source(32'sd100, 1'b1, 1'b1);
        send_source(-32'sd100, 1'b0, 1'b0);
        send_source(-32'sd100, 1'b1, 1'b0);
        set_mix_config(FMT_S32, GAIN_UNITY);
        send_source(32'h7fff_ffff, 1'b1, 1'b0);
        send_source(32'h8000_0000, 1'b1, 1'b1);
        send_source(32'h7fff_ffff, 1'b0, 1'b0);
        send_source(32'sd1, 1'b1, 1'b0);
        set_mix_config(FMT_UNUSED, GAIN_UNITY);
        send_source(32'h8000_0000, 1'b1, 1'b0);
        send_source(32'h0001_2345, 1'b1, 1'b1);
    endtask

    task automatic test_gain_extremes();
        set_mix_config(FMT_S16, GAIN_MAX);
        send_source(32'sd32767, 1'b1, 1'b0);
        send_source(-32'sd3, 1'b1, 1'b1);
        set_mix_config(FMT_S16, 20'd0);
        send_source(32'sd12345, 1'b1, 1'b0);
        set_mix_config(FMT_S32, 20'd65535);
        send_source(-32'sd1, 1'b1, 1'b0);
        set_mix_config(FMT_S32, 20'd32768);
        send_source(-32'sd3, 1'b1, 1'b0);
        send_source(32'sd3, 1'b1, 1'b1);
    endtask

    task automatic test_random_mix(input int n_items);
        int sent;
        int n_src;
        sent = 0;
        while (sent < n_items)
        begin
            n_src = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            for (int k = 0; k < n_src; k++)
            begin
                if (k == n_src / 2 && $urandom_range(59) == 0)
                begin
                    wait_drain();
                end
                send_source(pick_sample(), k == n_src - 1, $urandom_range(3) == 0);
            end
            sent = sent + n_src;
            if ($urandom_range(29) == 0)
            begin
                wait_drain();
            end
        end
    endtask

    task automatic test_random_phases();
        logic [GAIN_W-1:0] gain;
        for (int ph = 0; ph < 6; ph++)
        begin
            case ($urandom_range(4))
                0: gain = GAIN_MAX;
                1: gain = 20'd0;
                2: gain = GAIN_UNITY;
                3: gain = GAIN_W'($urandom_range(131072));
                default: gain = GAIN_W'($urandom);
            endcase
            if (ph == 0)
            begin
                set_mix_config(FMT_S8, GAIN_MAX);
            end
            else if (ph == 1)
            begin
                set_mix_config(FMT_S32, 20'd1);
            end
            else
            begin
                set_mix_config(FMT_W'($urandom_range(3)), gain);
            end
            idle_on = (ph != 3);
            test_random_mix(80);
            idle_on = 1'b1;
        end
    endtask

    task automatic test_deep_accumulation();
        set_mix_config(FMT_S32, GAIN_MAX);
        for (int k = 0; k < 256; k++)
        begin
            send_source((k % 2 == 0) ? 32'h7fff_ffff : $urandom, k == 255, 1'b1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        source_sample = '0;
        last_source = 1'b0;
        end_of_block = 1'b0;
        out_stall = 1'b0;
        fmt_q = FMT_RESET;
        gain_q = GAIN_RESET;
        mix_acc = 0;
        mismatch_count = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_format_extremes();
        test_gain_extremes();
        test_random_phases();
        test_deep_accumulation();
        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_mixes.size() == 0)
        begin
            $display("saturating_audio_mixer_top_tb: done, clean");
        end
        else
        begin
            $display("saturating_audio_mixer_top_tb: done, errors");
        end
        $finish;
    end

endmodule
